[design/lcdd_pkg.sv]
// Shared types, constants and keyword tables for the line command deframer/decoder.
// No dependencies.
`timescale 1ns / 1ps
package lcdd_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int LINE_LIMIT  = 255;
    localparam int ENT_AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ECNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int BCNT_W      = $clog2(LINE_LIMIT + 1);
    localparam int ENT_W       = 48;

    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [2:0] PH_MATCH = 3'd0;
    localparam logic [2:0] PH_FIELD = 3'd1;
    localparam logic [2:0] PH_SKIP  = 3'd2;
    localparam logic [2:0] PH_READY = 3'd3;
    localparam logic [2:0] PH_DEAD  = 3'd4;

    localparam logic [2:0] KIND_ASSIGN = 3'd0;
    localparam logic [2:0] KIND_MAINT  = 3'd1;
    localparam logic [2:0] KIND_FREE   = 3'd2;
    localparam logic [2:0] KIND_DEPART = 3'd3;
    localparam logic [2:0] KIND_ESTOP  = 3'd4;
    localparam logic [2:0] KIND_SYN    = 3'd5;
    localparam logic [2:0] KIND_NONE   = 3'd7;

    localparam logic [2:0] WORD_BOARD = 3'd0;
    localparam logic [2:0] WORD_NONE  = 3'd7;
    localparam logic [6:0] ALL_WORDS  = 7'h7F;
    localparam logic [6:0] KEY_WORDS  = 7'h7E;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_TEXT = 2'd1;
    localparam logic [1:0] MODE_BIN  = 2'd2;

    typedef struct packed {
        logic       start;
        logic       feed;
        logic       fin;
        logic [7:0] c;
    } lcdd_op_t;

    typedef struct packed {
        logic [7:0]        run_xor;
        logic [2:0]        phase;
        logic [2:0]        kind;
        logic [15:0]       f0;
        logic [15:0]       f1;
        logic [ECNT_W-1:0] ent_cnt;
    } lcdd_stat_t;

    typedef struct packed {
        logic              we;
        logic [ENT_AW-1:0] addr;
        logic [ENT_W-1:0]  data;
    } lcdd_wr_t;

    function automatic logic [3:0] word_len(input logic [2:0] w);
        case (w)
            3'd0: return 4'd8;
            3'd1: return 4'd13;
            3'd2: return 4'd12;
            3'd3: return 4'd11;
            3'd4: return 4'd7;
            3'd5: return 4'd15;
            3'd6: return 4'd9;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] word_char(input logic [2:0] w, input logic [3:0] pos);
        logic [119:0] s;
        logic [3:0]   idx;
        case (w)
            3'd0: s = 120'("[BOARD] ");
            3'd1: s = 120'({"TRACK_", "ASSIGN:"});
            3'd2: s = 120'({"TRACK_", "MAINT:"});
            3'd3: s = 120'({"TRACK_", "FREE:"});
            3'd4: s = 120'("DEPART:");
            3'd5: s = 120'({"EMERGENCY_", "STOP:"});
            3'd6: s = 120'("SYNOPSIS:");
            default: s = '0;
        endcase
        idx = word_len(w) - 4'd1 - pos;
        return s[{idx, 3'b000} +: 8];
    endfunction

    function automatic logic [1:0] fields_needed(input logic [2:0] k);
        case (k)
            KIND_ASSIGN, KIND_DEPART: return 2'd2;
            KIND_SYN:                 return 2'd3;
            default:                  return 2'd1;
        endcase
    endfunction

endpackage

[design/line_command_deframer_decoder_top.sv]
// Top level: line framing, checksum check and result sequencing.
// Depends on lcdd_pkg, lcdd_parser, lcdd_entry_ram.
//
//  channel | ports                                       | direction
//  input   | s_valid s_ready s_byte_in                   | in
//  result  | m_valid m_ready m_kind m_track m_train      | out
//          | m_track_state m_last                        |
//
// One byte per cycle while a line is being received.
// The LF of a command line parks its result; a synopsis line then plays out its
// entries from the entry store in read and load states. s_ready is low while a
// result is parked and during play-out. Reset is synchronous, active low.
`timescale 1ns / 1ps
module line_command_deframer_decoder_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_byte_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic signed [15:0] m_track,
    output logic signed [15:0] m_train,
    output logic signed [15:0] m_track_state,
    output logic               m_last
);
    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_PEND = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    lcdd_pkg::lcdd_op_t   op;
    lcdd_pkg::lcdd_stat_t stat;
    lcdd_pkg::lcdd_wr_t   wr;
    logic [lcdd_pkg::ENT_W-1:0] rdata;

    logic [1:0]                  st_reg, st_next;
    logic [1:0]                  mode_reg, mode_next;
    logic [lcdd_pkg::BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic [7:0]                  held_reg, held_next;
    logic [lcdd_pkg::ENT_AW-1:0] ridx_reg, ridx_next;
    logic [lcdd_pkg::ENT_AW-1:0] rlast_reg, rlast_next;
    logic [2:0]                  pkind_reg, pkind_next;
    logic [15:0]                 ptrk_reg, ptrk_next;
    logic [15:0]                 ptrn_reg, ptrn_next;
    logic                        mv_reg, mv_next;
    logic [2:0]                  mk_reg, mk_next;
    logic [15:0]                 mtrk_reg, mtrk_next;
    logic [15:0]                 mtrn_reg, mtrn_next;
    logic [15:0]                 mst_reg, mst_next;
    logic                        ml_reg, ml_next;
    logic                        re;
    logic                        acc;
    logic                        out_free;
    logic                        valid_line;

    assign s_ready  = (st_reg == S_RUN);
    assign acc      = s_valid && s_ready;
    assign out_free = !mv_reg || m_ready;

    lcdd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .stat    (stat),
        .wr      (wr)
    );

    lcdd_entry_ram u_ram (
        .aclk  (aclk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (re),
        .raddr (ridx_reg),
        .rdata (rdata)
    );

    always_comb begin
        op = '0;
        op.c = s_byte_in;
        st_next = st_reg; mode_next = mode_reg; bcnt_next = bcnt_reg;
        held_next = held_reg; ridx_next = ridx_reg; rlast_next = rlast_reg;
        pkind_next = pkind_reg; ptrk_next = ptrk_reg; ptrn_next = ptrn_reg;
        mv_next = mv_reg && !m_ready;
        mk_next = mk_reg; mtrk_next = mtrk_reg; mtrn_next = mtrn_reg;
        mst_next = mst_reg; ml_next = ml_reg;
        re = 1'b0;
        valid_line = (mode_reg == lcdd_pkg::MODE_TEXT) ||
                     (bcnt_reg != '0 && stat.run_xor == held_reg);
        case (st_reg)
            S_RUN: begin
                if (acc) begin
                    if (mode_reg == lcdd_pkg::MODE_IDLE) begin
                        if (s_byte_in == lcdd_pkg::CH_STX) begin
                            op.start = 1'b1;
                            mode_next = lcdd_pkg::MODE_BIN;
                            bcnt_next = '0;
                            held_next = '0;
                        end else if (s_byte_in != lcdd_pkg::CH_LF &&
                                     s_byte_in != lcdd_pkg::CH_CR &&
                                     s_byte_in != lcdd_pkg::CH_SP) begin
                            op.start = 1'b1;
                            op.feed = 1'b1;
                            mode_next = lcdd_pkg::MODE_TEXT;
                            bcnt_next = lcdd_pkg::BCNT_W'(1);
                            held_next = '0;
                        end
                    end else if (s_byte_in == lcdd_pkg::CH_LF) begin
                        op.fin = 1'b1;
                        mode_next = lcdd_pkg::MODE_IDLE;
                        if (valid_line) begin
                            if (stat.kind == lcdd_pkg::KIND_SYN) begin
                                if (stat.ent_cnt != '0) begin
                                    ridx_next = '0;
                                    rlast_next = lcdd_pkg::ENT_AW'(stat.ent_cnt - 1'b1);
                                    st_next = S_RD;
                                end
                            end else if (stat.kind <= lcdd_pkg::KIND_ESTOP &&
                                         stat.phase == lcdd_pkg::PH_READY) begin
                                pkind_next = stat.kind;
                                case (stat.kind)
                                    lcdd_pkg::KIND_ASSIGN, lcdd_pkg::KIND_DEPART: begin
                                        ptrk_next = stat.f0; ptrn_next = stat.f1;
                                    end
                                    lcdd_pkg::KIND_ESTOP: begin
                                        ptrk_next = '0; ptrn_next = stat.f0;
                                    end
                                    default: begin
                                        ptrk_next = stat.f0; ptrn_next = '0;
                                    end
                                endcase
                                st_next = S_PEND;
                            end
                        end
                    end else if (bcnt_reg < lcdd_pkg::BCNT_W'(lcdd_pkg::LINE_LIMIT)) begin
                        if (mode_reg == lcdd_pkg::MODE_TEXT) begin
                            op.feed = 1'b1;
                        end else begin
                            op.feed = (bcnt_reg != '0);
                            op.c = held_reg;
                            held_next = s_byte_in;
                        end
                        bcnt_next = bcnt_reg + 1'b1;
                    end
                end
            end
            S_PEND: begin
                if (out_free) begin
                    mv_next = 1'b1; mk_next = pkind_reg; mtrk_next = ptrk_reg;
                    mtrn_next = ptrn_reg; mst_next = '0; ml_next = 1'b1;
                    st_next = S_RUN;
                end
            end
            S_RD: begin
                re = 1'b1;
                st_next = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    mv_next = 1'b1; mk_next = lcdd_pkg::KIND_SYN;
                    mtrk_next = rdata[47:32]; mtrn_next = rdata[31:16];
                    mst_next = rdata[15:0]; ml_next = (ridx_reg == rlast_reg);
                    if (ridx_reg == rlast_reg) begin
                        st_next = S_RUN;
                    end else begin
                        ridx_next = ridx_reg + 1'b1;
                        st_next = S_RD;
                    end
                end
            end
            default: st_next = S_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_RUN; mode_reg <= lcdd_pkg::MODE_IDLE; bcnt_reg <= '0;
            held_reg <= '0; ridx_reg <= '0; rlast_reg <= '0; mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next; mode_reg <= mode_next; bcnt_reg <= bcnt_next;
            held_reg <= held_next; ridx_reg <= ridx_next; rlast_reg <= rlast_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        pkind_reg <= pkind_next; ptrk_reg <= ptrk_next; ptrn_reg <= ptrn_next;
        mk_reg <= mk_next; mtrk_reg <= mtrk_next; mtrn_reg <= mtrn_next;
        mst_reg <= mst_next; ml_reg <= ml_next;
    end

    assign m_valid       = mv_reg;
    assign m_kind        = mk_reg;
    assign m_track       = mtrk_reg;
    assign m_train       = mtrn_reg;
    assign m_track_state = mst_reg;
    assign m_last        = ml_reg;
endmodule

[design/lcdd_entry_ram.sv]
// Synopsis entry store: one write port, one registered read port.
// Depends on lcdd_pkg.
`timescale 1ns / 1ps
module lcdd_entry_ram (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [lcdd_pkg::ENT_AW-1:0] waddr,
    input  logic [lcdd_pkg::ENT_W-1:0]  wdata,
    input  logic                      re,
    input  logic [lcdd_pkg::ENT_AW-1:0] raddr,
    output logic [lcdd_pkg::ENT_W-1:0]  rdata
);
    logic [lcdd_pkg::ENT_W-1:0] mem [lcdd_pkg::MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

[design/lcdd_parser.sv]
// Keyword matcher and decimal field parser, one character per cycle.
// Depends on lcdd_pkg; drives the entry store write port.
`timescale 1ns / 1ps
module lcdd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lcdd_pkg::lcdd_op_t   op,
    output lcdd_pkg::lcdd_stat_t stat,
    output lcdd_pkg::lcdd_wr_t   wr
);
    logic [7:0]                  xor_reg, xor_next;
    logic                        zero_reg, zero_next;
    logic [2:0]                  phase_reg, phase_next;
    logic [6:0]                  mset_reg, mset_next;
    logic [3:0]                  mpos_reg, mpos_next;
    logic [2:0]                  kind_reg, kind_next;
    logic [1:0]                  fpos_reg, fpos_next;
    logic [15:0]                 acc_reg, acc_next;
    logic                        sgn_reg, sgn_next;
    logic                        neg_reg, neg_next;
    logic                        dig_reg, dig_next;
    logic [2:0][15:0]            fv_reg, fv_next;
    logic [lcdd_pkg::ECNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        logic       do_char, do_fin, call_ff, do_begin, is_dig, is_sp;
        logic [7:0] c, ffc;
        logic [2:0] done;
        logic [19:0] prod;
        logic [15:0] v;
        xor_next = xor_reg; zero_next = zero_reg; phase_next = phase_reg;
        mset_next = mset_reg; mpos_next = mpos_reg; kind_next = kind_reg;
        fpos_next = fpos_reg; acc_next = acc_reg; sgn_next = sgn_reg;
        neg_next = neg_reg; dig_next = dig_reg; fv_next = fv_reg; cnt_next = cnt_reg;
        wr = '0;
        if (op.start) begin
            xor_next = '0; zero_next = 1'b0; phase_next = lcdd_pkg::PH_MATCH;
            mset_next = lcdd_pkg::ALL_WORDS; mpos_next = '0;
            kind_next = lcdd_pkg::KIND_NONE; fpos_next = '0; acc_next = '0;
            sgn_next = 1'b0; neg_next = 1'b0; dig_next = 1'b0; fv_next = '0;
            cnt_next = '0;
        end
        c = op.c;
        do_char = 1'b0; do_fin = op.fin;
        if (op.feed && !zero_next) begin
            if (c == 8'h00) begin
                zero_next = 1'b1;
                do_fin = 1'b1;
            end else begin
                xor_next = xor_next ^ c;
                do_char = 1'b1;
            end
        end
        is_dig = (c >= lcdd_pkg::CH_ZERO) && (c <= lcdd_pkg::CH_NINE);
        is_sp  = (c == lcdd_pkg::CH_SP) || ((c >= lcdd_pkg::CH_TAB) && (c <= lcdd_pkg::CH_CR));
        call_ff = 1'b0; ffc = c; do_begin = 1'b0; done = lcdd_pkg::WORD_NONE;
        prod = '0; v = '0;
        if (do_char) begin
            case (phase_next)
                lcdd_pkg::PH_MATCH: begin
                    for (int i = 0; i < 7; i++) begin
                        if (mset_next[i]) begin
                            if (mpos_next >= lcdd_pkg::word_len(3'(i)) ||
                                lcdd_pkg::word_char(3'(i), mpos_next) != c) begin
                                mset_next[i] = 1'b0;
                            end else if (mpos_next + 4'd1 == lcdd_pkg::word_len(3'(i))) begin
                                done = 3'(i);
                            end
                        end
                    end
                    mpos_next = mpos_next + 4'd1;
                    if (done == lcdd_pkg::WORD_BOARD) begin
                        mset_next = lcdd_pkg::KEY_WORDS;
                        mpos_next = '0;
                    end else if (done != lcdd_pkg::WORD_NONE) begin
                        kind_next = done - 3'd1;
                        do_begin = 1'b1;
                    end else if (mset_next == '0) begin
                        phase_next = lcdd_pkg::PH_DEAD;
                    end
                end
                lcdd_pkg::PH_FIELD: begin
                    if (dig_next) begin
                        if (is_dig) begin
                            prod = {4'd0, acc_next} * 20'd10 + 20'(c - lcdd_pkg::CH_ZERO);
                            acc_next = (prod > 20'd32768) ? 16'd32768 : prod[15:0];
                        end else begin
                            call_ff = 1'b1;
                        end
                    end else if (is_dig) begin
                        acc_next = 16'(c - lcdd_pkg::CH_ZERO);
                        dig_next = 1'b1;
                    end else if (!sgn_next &&
                                 (c == lcdd_pkg::CH_PLUS || c == lcdd_pkg::CH_MINUS)) begin
                        sgn_next = 1'b1;
                        neg_next = (c == lcdd_pkg::CH_MINUS);
                    end else if (!(!sgn_next && is_sp)) begin
                        phase_next = lcdd_pkg::PH_DEAD;
                    end
                end
                lcdd_pkg::PH_SKIP: begin
                    if (c == lcdd_pkg::CH_COLON) begin
                        do_begin = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (do_fin && phase_next == lcdd_pkg::PH_FIELD && dig_next) begin
            call_ff = 1'b1;
            ffc = 8'h00;
        end
        if (call_ff) begin
            if (neg_next) begin
                v = 16'd0 - acc_next;
            end else begin
                v = (acc_next > 16'd32767) ? 16'd32767 : acc_next;
            end
            if (fpos_next != 2'd3) begin
                fv_next[fpos_next] = v;
            end
            if (kind_next > lcdd_pkg::KIND_SYN) begin
                phase_next = lcdd_pkg::PH_DEAD;
            end else if (3'(fpos_next) + 3'd1 >= 3'(lcdd_pkg::fields_needed(kind_next))) begin
                if (kind_next != lcdd_pkg::KIND_SYN) begin
                    phase_next = lcdd_pkg::PH_READY;
                end else begin
                    if (cnt_next < lcdd_pkg::ECNT_W'(lcdd_pkg::MAX_ENTRIES)) begin
                        wr.we   = 1'b1;
                        wr.addr = cnt_next[lcdd_pkg::ENT_AW-1:0];
                        wr.data = {fv_next[0], fv_next[1], fv_next[2]};
                        cnt_next = cnt_next + 1'b1;
                    end
                    if (ffc == lcdd_pkg::CH_COLON) begin
                        do_begin = 1'b1;
                    end else begin
                        phase_next = lcdd_pkg::PH_SKIP;
                    end
                end
            end else if (ffc == lcdd_pkg::CH_COLON) begin
                fpos_next = fpos_next + 2'd1;
                acc_next = '0; sgn_next = 1'b0; neg_next = 1'b0; dig_next = 1'b0;
            end else begin
                phase_next = lcdd_pkg::PH_DEAD;
            end
        end
        if (do_begin) begin
            if (cnt_next >= lcdd_pkg::ECNT_W'(lcdd_pkg::MAX_ENTRIES)) begin
                phase_next = lcdd_pkg::PH_DEAD;
            end else begin
                fpos_next = '0; acc_next = '0; sgn_next = 1'b0; neg_next = 1'b0;
                dig_next = 1'b0; phase_next = lcdd_pkg::PH_FIELD;
            end
        end
        if (do_fin && phase_next != lcdd_pkg::PH_READY) begin
            phase_next = lcdd_pkg::PH_DEAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xor_reg <= '0; zero_reg <= 1'b0; phase_reg <= lcdd_pkg::PH_MATCH;
            mset_reg <= lcdd_pkg::ALL_WORDS; mpos_reg <= '0;
            kind_reg <= lcdd_pkg::KIND_NONE; fpos_reg <= '0; acc_reg <= '0;
            sgn_reg <= 1'b0; neg_reg <= 1'b0; dig_reg <= 1'b0; fv_reg <= '0;
            cnt_reg <= '0;
        end else begin
            xor_reg <= xor_next; zero_reg <= zero_next; phase_reg <= phase_next;
            mset_reg <= mset_next; mpos_reg <= mpos_next; kind_reg <= kind_next;
            fpos_reg <= fpos_next; acc_reg <= acc_next; sgn_reg <= sgn_next;
            neg_reg <= neg_next; dig_reg <= dig_next; fv_reg <= fv_next;
            cnt_reg <= cnt_next;
        end
    end

    assign stat.run_xor = xor_reg;
    assign stat.phase   = phase_next;
    assign stat.kind    = kind_next;
    assign stat.f0      = fv_next[0];
    assign stat.f1      = fv_next[1];
    assign stat.ent_cnt = cnt_next;
endmodule

[verif/tb_line_command_deframer_decoder_top.sv]
// Testbench for line_command_deframer_decoder_top: drives serial command bytes
// and checks the decoded commands against an in-bench line decoder model.
// Depends on lcdd_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_line_command_deframer_decoder_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 600;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] track;
        logic [15:0] train;
        logic [15:0] tstate;
        logic        last;
    } cmd_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_byte_in;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_kind;
    logic signed [15:0] m_track;
    logic signed [15:0] m_train;
    logic signed [15:0] m_track_state;
    logic               m_last;

    line_command_deframer_decoder_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_byte_in(s_byte_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_track(m_track), .m_train(m_train), .m_track_state(m_track_state),
        .m_last(m_last)
    );

    logic [7:0] byte_q[$];
    cmd_t       cmd_q[$];
    int         mismatches;
    int         cmds_seen;

    // line decoder model state
    string      keywords[7];
    int         field_count[6] = '{2, 1, 1, 2, 1, 3};
    logic [1:0] ln_mode;
    int         ln_bytes;
    logic [7:0] ln_xor;
    logic [7:0] ln_held;
    bit         ln_zero;
    int         kw_pos;
    logic [6:0] kw_set;
    logic [2:0] ph;
    logic [2:0] cmd_kind;
    int         fld_pos;
    int         num_acc;
    bit         num_sign, num_neg, num_dig;
    int         fld_val[3];
    int         ent_cnt;
    int         ent_mem[lcdd_pkg::MAX_ENTRIES][3];

    task automatic num_clear();
        num_acc = 0;
        num_sign = 0;
        num_neg = 0;
        num_dig = 0;
    endtask

    task automatic entry_open();
        if (ent_cnt >= lcdd_pkg::MAX_ENTRIES) begin
            ph = lcdd_pkg::PH_DEAD;
        end else begin
            fld_pos = 0;
            num_clear();
            ph = lcdd_pkg::PH_FIELD;
        end
    endtask

    task automatic line_open();
        ln_bytes = 0;
        ln_xor = 0;
        ln_held = 0;
        ln_zero = 0;
        kw_pos = 0;
        kw_set = lcdd_pkg::ALL_WORDS;
        ph = lcdd_pkg::PH_MATCH;
        cmd_kind = lcdd_pkg::KIND_NONE;
        fld_pos = 0;
        num_clear();
        fld_val = '{0, 0, 0};
        ent_cnt = 0;
    endtask

    task automatic field_close(input logic [7:0] c);
        int v;
        v = num_acc;
        if (num_neg) v = -v;
        else if (v > 32767) v = 32767;
        if (fld_pos < 3) fld_val[fld_pos] = v;
        if (cmd_kind > lcdd_pkg::KIND_SYN) begin
            ph = lcdd_pkg::PH_DEAD;
        end else if (fld_pos + 1 >= field_count[cmd_kind]) begin
            if (cmd_kind != lcdd_pkg::KIND_SYN) begin
                ph = lcdd_pkg::PH_READY;
            end else begin
                if (ent_cnt < lcdd_pkg::MAX_ENTRIES) begin
                    ent_mem[ent_cnt] = fld_val;
                    ent_cnt++;
                end
                if (c == lcdd_pkg::CH_COLON) entry_open();
                else ph = lcdd_pkg::PH_SKIP;
            end
        end else if (c == lcdd_pkg::CH_COLON) begin
            fld_pos++;
            num_clear();
        end else begin
            ph = lcdd_pkg::PH_DEAD;
        end
    endtask

    task automatic parse_byte(input logic [7:0] c);
        bit         dig;
        logic [6:0] set;
        int         done;
        dig = (c >= lcdd_pkg::CH_ZERO && c <= lcdd_pkg::CH_NINE);
        if (ph == lcdd_pkg::PH_MATCH) begin
            set = kw_set;
            done = -1;
            for (int i = 0; i < 7; i++) begin
                if (set[i]) begin
                    if (kw_pos >= keywords[i].len() || keywords[i][kw_pos] != c)
                        set[i] = 1'b0;
                    else if (kw_pos + 1 == keywords[i].len())
                        done = i;
                end
            end
            kw_pos++;
            kw_set = set;
            if (done == 0) begin
                kw_set = lcdd_pkg::KEY_WORDS;
                kw_pos = 0;
            end else if (done > 0) begin
                cmd_kind = 3'(done - 1);
                entry_open();
            end else if (set == 0) begin
                ph = lcdd_pkg::PH_DEAD;
            end
        end else if (ph == lcdd_pkg::PH_FIELD) begin
            if (num_dig) begin
                if (dig) begin
                    num_acc = num_acc * 10 + (c - lcdd_pkg::CH_ZERO);
                    if (num_acc > 32768) num_acc = 32768;
                end else begin
                    field_close(c);
                end
            end else if (dig) begin
                num_acc = c - lcdd_pkg::CH_ZERO;
                num_dig = 1;
            end else if (!num_sign && (c == lcdd_pkg::CH_PLUS || c == lcdd_pkg::CH_MINUS)) begin
                num_sign = 1;
                num_neg = (c == lcdd_pkg::CH_MINUS);
            end else if (!num_sign && (c == lcdd_pkg::CH_SP ||
                                       (c >= lcdd_pkg::CH_TAB && c <= lcdd_pkg::CH_CR))) begin
            end else begin
                ph = lcdd_pkg::PH_DEAD;
            end
        end else if (ph == lcdd_pkg::PH_SKIP) begin
            if (c == lcdd_pkg::CH_COLON) entry_open();
        end
    endtask

    task automatic parse_end();
        if (ph == lcdd_pkg::PH_FIELD && num_dig) field_close(8'h00);
        if (ph != lcdd_pkg::PH_READY) ph = lcdd_pkg::PH_DEAD;
    endtask

    task automatic string_byte(input logic [7:0] c);
        if (!ln_zero) begin
            if (c == 8'h00) begin
                ln_zero = 1;
                parse_end();
            end else begin
                ln_xor ^= c;
                parse_byte(c);
            end
        end
    endtask

    task automatic add_cmd(input logic [2:0] k, input int a, input int b, input int s,
                           input bit l);
        cmd_t e;
        e.kind = k;
        e.track = a[15:0];
        e.train = b[15:0];
        e.tstate = s[15:0];
        e.last = l;
        cmd_q.push_back(e);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        bit ok;
        if (ln_mode == lcdd_pkg::MODE_IDLE) begin
            if (b == lcdd_pkg::CH_STX) begin
                line_open();
                ln_mode = lcdd_pkg::MODE_BIN;
            end else if (b != lcdd_pkg::CH_LF && b != lcdd_pkg::CH_CR &&
                         b != lcdd_pkg::CH_SP) begin
                line_open();
                ln_mode = lcdd_pkg::MODE_TEXT;
                ln_bytes = 1;
                string_byte(b);
            end
        end else if (b == lcdd_pkg::CH_LF) begin
            ok = (ln_mode == lcdd_pkg::MODE_TEXT) || (ln_bytes > 0 && ln_xor == ln_held);
            parse_end();
            if (ok) begin
                if (cmd_kind == lcdd_pkg::KIND_SYN) begin
                    for (int k = 0; k < ent_cnt; k++)
                        add_cmd(lcdd_pkg::KIND_SYN, ent_mem[k][0], ent_mem[k][1],
                                ent_mem[k][2], k + 1 == ent_cnt);
                end else if (ph == lcdd_pkg::PH_READY) begin
                    case (cmd_kind)
                        lcdd_pkg::KIND_ASSIGN, lcdd_pkg::KIND_DEPART:
                            add_cmd(cmd_kind, fld_val[0], fld_val[1], 0, 1);
                        lcdd_pkg::KIND_MAINT, lcdd_pkg::KIND_FREE:
                            add_cmd(cmd_kind, fld_val[0], 0, 0, 1);
                        lcdd_pkg::KIND_ESTOP:
                            add_cmd(cmd_kind, 0, fld_val[0], 0, 1);
                        default: ;
                    endcase
                end
            end
            ln_mode = lcdd_pkg::MODE_IDLE;
        end else if (ln_bytes < lcdd_pkg::LINE_LIMIT) begin
            if (ln_mode == lcdd_pkg::MODE_TEXT) begin
                string_byte(b);
            end else begin
                if (ln_bytes > 0) string_byte(ln_held);
                ln_held = b;
            end
            ln_bytes++;
        end
    endtask

    // stimulus helpers
    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
    endtask

    task automatic put_text(input string s);
        put_str(s);
        byte_q.push_back(lcdd_pkg::CH_LF);
    endtask

    task automatic put_frame(input string s, input bit bad_sum, input bit zero_tail);
        logic [7:0] x;
        x = 0;
        for (int i = 0; i < s.len(); i++) x ^= s[i];
        byte_q.push_back(lcdd_pkg::CH_STX);
        put_str(s);
        if (zero_tail) begin
            byte_q.push_back(8'h00);
            put_str("zz");
        end
        byte_q.push_back(bad_sum ? x ^ 8'h5A : x);
        byte_q.push_back(lcdd_pkg::CH_LF);
    endtask

    function automatic string num_text();
        case ($urandom_range(0, 9))
            0: return $sformatf("%0d", $urandom_range(0, 32767));
            1: return $sformatf("-%0d", $urandom_range(0, 32768));
            2: return $sformatf("+%0d", $urandom_range(0, 999));
            3: return $sformatf(" \t%0d", $urandom_range(0, 99));
            4: return "123456";
            5: return "-99999";
            6: return "x";
            default: return $sformatf("%0d", $urandom_range(0, 99));
        endcase
    endfunction

    function automatic string cmd_text();
        string s;
        int    k;
        int    n;
        s = ($urandom_range(0, 3) == 0) ? keywords[0] : "";
        k = $urandom_range(0, 5);
        s = {s, keywords[k + 1]};
        if (k == 5) begin
            n = $urandom_range(1, 4);
            for (int e = 0; e < n; e++) begin
                s = {s, num_text(), ":", num_text(), ":", num_text()};
                if (e + 1 < n) s = {s, ($urandom_range(0, 1) != 0) ? ":" : ",ab:"};
            end
        end else begin
            s = {s, num_text()};
            if (field_count[k] == 2) s = {s, ":", num_text()};
        end
        if ($urandom_range(0, 3) == 0) s = {s, " ok"};
        if ($urandom_range(0, 6) == 0)
            s.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(11, 255)));
        return s;
    endfunction

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        string pad;
        string us;
        us = "_";
        keywords[0] = "[BOARD] ";
        keywords[1] = {"TRACK", us, "ASSIGN:"};
        keywords[2] = {"TRACK", us, "MAINT:"};
        keywords[3] = {"TRACK", us, "FREE:"};
        keywords[4] = "DEPART:";
        keywords[5] = {"EMERGENCY", us, "STOP:"};
        keywords[6] = "SYNOPSIS:";
        aresetn = 0;
        // directed
        put_text({keywords[1], "12:34"});
        put_text({keywords[3], "+32767"});
        put_text({keywords[4], " 5:-32768"});
        put_text({keywords[5], "99999"});
        put_text({keywords[0], keywords[6], "1:2:3:4:5:6,xy:7:8:9"});
        pad = keywords[6];
        for (int i = 0; i < 17; i++)
            pad = {pad, $sformatf("%0d:%0d:%0d:", i % 10, 9 - (i % 10), i % 4)};
        put_text(pad);
        put_text({keywords[6], "x"});
        put_text({keywords[1], "1,2"});
        put_text("BOGUS:1");
        put_frame({keywords[4], "3:4"}, 0, 0);
        put_frame({keywords[3], "8"}, 1, 0);
        put_frame({keywords[3], "9"}, 0, 1);
        byte_q.push_back(lcdd_pkg::CH_STX);
        byte_q.push_back(lcdd_pkg::CH_LF);
        put_str({keywords[3], "7"});
        byte_q.push_back(8'h00);
        put_text("99");
        put_str(" \r\n");
        byte_q.push_back(8'hFF);
        byte_q.push_back(lcdd_pkg::CH_LF);
        // random
        while (byte_q.size() < 340) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) byte_q.push_back(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 1) != 0) begin
                put_frame(cmd_text(), $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0);
            end else begin
                put_text(cmd_text());
            end
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        while (byte_q.size() != 0 || s_valid) @(posedge aclk);
        while (cmd_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && cmd_q.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // driver
    int  gap;
    bit  burst;
    initial begin
        s_valid = 0;
        s_byte_in = 0;
        m_ready = 0;
        mismatches = 0;
        cmds_seen = 0;
        gap = 0;
        burst = 0;
        ln_mode = lcdd_pkg::MODE_IDLE;
        line_open();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else begin
            if (s_valid && s_ready) decode_byte(s_byte_in);
            if (!s_valid || s_ready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    s_valid <= 0;
                end else if (byte_q.size() != 0) begin
                    s_valid <= 1;
                    s_byte_in <= byte_q.pop_front();
                    if ($urandom_range(0, 19) == 0) burst <= ~burst;
                    gap <= burst ? 0 : $urandom_range(0, 16);
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // monitor
    int   stall;
    int   hold;
    cmd_t want;
    initial begin
        stall = 0;
        hold = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                cmds_seen++;
                if (cmd_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("ERROR: unexpected transfer kind=%0d", m_kind);
                end else begin
                    want = cmd_q.pop_front();
                    if (m_kind !== want.kind || m_track !== want.track ||
                        m_train !== want.train || m_track_state !== want.tstate ||
                        m_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                     want.kind, $signed(want.track), $signed(want.train),
                                     $signed(want.tstate), want.last, m_kind, m_track,
                                     m_train, m_track_state, m_last);
                    end
                end
            end
            if (hold > 0) begin
                hold <= hold - 1;
                m_ready <= 0;
            end else if (m_valid && m_ready) begin
                if (cmds_seen == 3) begin
                    hold <= LONG_HOLD;
                    m_ready <= 0;
                end else begin
                    stall <= burst ? 0 : $urandom_range(0, 16);
                    m_ready <= burst;
                end
            end else if (stall > 0) begin
                stall <= stall - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // watchdog
    int idle_cycles;
    initial idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
